/* src/tma_pkg.sv */
package tma_pkg;

  localparam int FIELD_W              = 24;
  localparam int AXIS_COUNT           = 3;
  localparam int RATE_W               = 10;
  localparam int MAXW_W               = 6;
  localparam int CFG_IDX_W            = 1;
  localparam int CFG_DATA_W           = RATE_W;
  localparam int DEFAULT_WINDOW_DEPTH = 32;

  localparam logic [RATE_W-1:0] MIN_AVG_RATE     = RATE_W'(2);
  localparam logic [MAXW_W-1:0] MAX_WINDOW_RESET = MAXW_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW  = 1'b1;

  typedef logic signed [FIELD_W-1:0] field_t;

endpackage

/* src/tma_div.sv */
module tma_div import tma_pkg::*; #(
  parameter int SUM_W = FIELD_W + 5,
  parameter int DIV_W = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output field_t                  quotient_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W-1:0] rem_q;
  logic [SUM_W-1:0] quo_q;

  logic [SUM_W-1:0] mag;
  logic [DIV_W:0]   trial;
  logic             fits;
  logic [DIV_W:0]   diff;
  logic [SUM_W-1:0] signed_quo;

  assign mag   = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // restoring divide on the magnitude, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= dividend_i[SUM_W-1];
        cnt_q  <= CNT_W'(SUM_W);
        den_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= mag;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = signed_quo[FIELD_W-1:0];
  assign done_o     = done_q;

endmodule

/* src/three_axis_moving_average.sv */
// Three-axis moving average. Each item is one x/y/z sample (signed, 8 fraction bits);
// each result is the per-axis mean over the last W samples, W = min(sample rate,
// max_window) clamped to 1..WINDOW_DEPTH, truncated toward zero. While the window
// fills, the mean is over the samples taken so far. A sample rate below 2 passes
// samples through unchanged, and a change of W restarts the window. The three means
// share one restoring divider that yields one bit a cycle on sums of SUM_W =
// 24+clog2(WINDOW_DEPTH) bits. The next item is accepted only once the previous
// result has been loaded into the output register, but it may be accepted while
// that result still waits on a stalled output.
module three_axis_moving_average import tma_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  field_t                sample_x_i,
  input  field_t                sample_y_i,
  input  field_t                sample_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output field_t                mean_x_o,
  output field_t                mean_y_o,
  output field_t                mean_z_o
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int AW_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = FIELD_W + SLOT_W;
  localparam int ENT_W  = AXIS_COUNT * FIELD_W;
  localparam int AX_W   = $clog2(AXIS_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

  state_e                  state_q;
  logic [RATE_W-1:0]       rate_q;
  logic [MAXW_W-1:0]       maxw_q;
  logic [AW_W-1:0]         active_q;
  logic [AW_W-1:0]         fill_q;
  logic [SLOT_W-1:0]       evict_q;
  logic                    full_q;
  logic [AX_W-1:0]         ax_q;
  logic signed [SUM_W-1:0] sum_q [AXIS_COUNT];
  field_t                  in_q  [AXIS_COUNT];
  field_t                  res_q [AXIS_COUNT];
  field_t                  out_q [AXIS_COUNT];
  logic                    out_valid_q;

  logic [ENT_W-1:0]        ring_q [WINDOW_DEPTH];
  logic [ENT_W-1:0]        rd_q;

  logic [MAXW_W-1:0]       win_min;
  logic [MAXW_W-1:0]       win_nz;
  logic [AW_W-1:0]         win;
  logic                    in_acc;
  logic                    out_free;
  logic [SLOT_W:0]         evict_inc;
  logic                    div_start;
  logic                    div_done;
  field_t                  div_quo;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
      maxw_q <= MAX_WINDOW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE: rate_q <= cfg_data_i;
        CFG_MAX_WINDOW:  maxw_q <= cfg_data_i[MAXW_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    win_min = (rate_q > {{(RATE_W-MAXW_W){1'b0}}, maxw_q}) ? maxw_q : rate_q[MAXW_W-1:0];
    win_nz  = (win_min == '0) ? MAXW_W'(1) : win_min;
    win     = (int'(win_nz) > WINDOW_DEPTH) ? AW_W'(WINDOW_DEPTH) : AW_W'(win_nz);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign evict_inc  = {1'b0, evict_q} + 1'b1;
  assign div_start  = (state_q == S_DIV_GO);

  // ring memory, read in the state just before the update
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_q <= ring_q[evict_q];
    end
    if (state_q == S_UPDATE) begin
      ring_q[evict_q] <= {in_q[2], in_q[1], in_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      fill_q      <= '0;
      evict_q     <= '0;
      full_q      <= 1'b0;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        sum_q[a] <= '0;
        in_q[a]  <= '0;
        res_q[a] <= '0;
        out_q[a] <= '0;
      end
    end else begin
      // the finish state reloads the output itself
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            in_q[0] <= sample_x_i;
            in_q[1] <= sample_y_i;
            in_q[2] <= sample_z_i;
            if (rate_q < MIN_AVG_RATE) begin
              res_q[0] <= sample_x_i;
              res_q[1] <= sample_y_i;
              res_q[2] <= sample_z_i;
              state_q  <= S_FINISH;
            end else begin
              // new window length restarts the average
              if (win != active_q) begin
                active_q <= win;
                fill_q   <= '0;
                evict_q  <= '0;
                for (int a = 0; a < AXIS_COUNT; a++) begin
                  sum_q[a] <= '0;
                end
              end
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          full_q <= !(fill_q < active_q);
          if (fill_q < active_q) begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          for (int a = 0; a < AXIS_COUNT; a++) begin
            sum_q[a] <= sum_q[a]
                      - (full_q ? {{(SUM_W-FIELD_W){rd_q[a*FIELD_W+FIELD_W-1]}},
                                   rd_q[a*FIELD_W +: FIELD_W]} : SUM_W'(0))
                      + {{(SUM_W-FIELD_W){in_q[a][FIELD_W-1]}}, in_q[a]};
          end
          evict_q <= (evict_inc >= (SLOT_W+1)'(active_q)) ? '0 : evict_inc[SLOT_W-1:0];
          ax_q    <= '0;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_q[ax_q] <= div_quo;
            if (ax_q == AX_W'(AXIS_COUNT - 1)) begin
              state_q <= S_FINISH;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            for (int a = 0; a < AXIS_COUNT; a++) begin
              out_q[a] <= res_q[a];
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  tma_div #(
    .SUM_W(SUM_W),
    .DIV_W(AW_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q[ax_q]),
    .divisor_i (fill_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign mean_x_o    = out_q[0];
  assign mean_y_o    = out_q[1];
  assign mean_z_o    = out_q[2];

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= active_q)
    else $error("fill count beyond window");

  a_evict_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q == '0) || ({1'b0, evict_q} < (SLOT_W+1)'(active_q)))
    else $error("eviction slot outside window");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after item accepted");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (fill_q != '0))
    else $error("divide started with empty window");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import tma_pkg::*;

  localparam int DEPTH       = DEFAULT_WINDOW_DEPTH;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 112;

  typedef logic [AXIS_COUNT-1:0][FIELD_W-1:0] triple_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_SAMPLE_RATE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  field_t                sample_x_i  = '0;
  field_t                sample_y_i  = '0;
  field_t                sample_z_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  field_t                mean_x_o;
  field_t                mean_y_o;
  field_t                mean_z_o;

  three_axis_moving_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .sample_z_i  (sample_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_x_o    (mean_x_o),
    .mean_y_o    (mean_y_o),
    .mean_z_o    (mean_z_o)
  );

  // predicted filter state
  field_t ring [DEPTH][AXIS_COUNT];
  longint axis_sum [AXIS_COUNT];
  int     fill_count   = 0;
  int     evict_slot   = 0;
  int     active_win   = 0;
  int     rate_reg     = 0;
  int     max_win_reg  = int'(MAX_WINDOW_RESET);

  triple_t sample_q [$];
  triple_t mean_q [$];
  string   axis_name [AXIS_COUNT] = '{"mean_x", "mean_y", "mean_z"};

  int mismatch_count = 0;
  int samples_taken  = 0;
  int src_idle_pct   = 17;
  int sink_idle_pct  = 73;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  bit in_took        = 1'b0;
  int quiet_cycles   = 0;

  // per-phase register settings, -1 picks a random value
  int rate_set [PHASES] = '{1023, 2, 5, 1023, 1, 40, 7, 512, 0, -1, -1, 3};
  int win_set  [PHASES] = '{63, 20, 0, 32, 32, 32, 9, 33, 63, -1, -1, 1};

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic triple_t window_mean(triple_t smp);
    triple_t res;
    int      win;
    bit      full;
    if (rate_reg < int'(MIN_AVG_RATE)) return smp;
    win = (rate_reg > max_win_reg) ? max_win_reg : rate_reg;
    if (win < 1) win = 1;
    if (win > DEPTH) win = DEPTH;
    if (win != active_win) begin
      active_win = win;
      fill_count = 0;
      evict_slot = 0;
      for (int a = 0; a < AXIS_COUNT; a++) axis_sum[a] = 0;
    end
    full = (fill_count >= active_win);
    if (!full) fill_count++;
    if (evict_slot >= DEPTH) evict_slot = 0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      if (full) axis_sum[a] -= longint'(ring[evict_slot][a]);
      ring[evict_slot][a] = field_t'(smp[a]);
      axis_sum[a] += longint'(field_t'(smp[a]));
      res[a] = FIELD_W'(axis_sum[a] / longint'(fill_count));
    end
    evict_slot = (evict_slot + 1 >= active_win) ? 0 : evict_slot + 1;
    return res;
  endfunction

  function automatic field_t rand_field();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return field_t'(int'($urandom_range(31)) - 16);
      default: return field_t'($urandom());
    endcase
  endfunction

  task automatic push_sample(field_t x, field_t y, field_t z);
    sample_q.push_back({z, y, x});
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || mean_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(int rate, int win);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SAMPLE_RATE;
    cfg_data_i  <= CFG_DATA_W'(rate);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    // upper data bits are don't-care for max_window
    cfg_index_i <= CFG_MAX_WINDOW;
    cfg_data_i  <= CFG_DATA_W'(win & 63) | (CFG_DATA_W'($urandom_range(15)) << MAXW_W);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sample driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (rst_ni && sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        sample_x_i <= sample_q[0][0];
        sample_y_i <= sample_q[0][1];
        sample_z_i <= sample_q[0][2];
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // result stall, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!hold_done && samples_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    triple_t got;
    triple_t want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SAMPLE_RATE: rate_reg = int'(cfg_data_i);
        CFG_MAX_WINDOW:  max_win_reg = int'(cfg_data_i[MAXW_W-1:0]);
        default: ;
      endcase
    end
    if (out_valid_o && !out_stall_i) begin
      got = {mean_z_o, mean_y_o, mean_x_o};
      if (mean_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < 100) $error("result item with no sample pending");
      end else begin
        want = mean_q.pop_front();
        for (int a = 0; a < AXIS_COUNT; a++) begin
          if (got[a] !== want[a]) begin
            mismatch_count++;
            if (mismatch_count < 100)
              $error("%s: expected %0d, got %0d", axis_name[a],
                     field_t'(want[a]), field_t'(got[a]));
          end
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      mean_q.push_back(window_mean({sample_z_i, sample_y_i, sample_x_i}));
      void'(sample_q.pop_front());
      samples_taken++;
      in_took = 1'b1;
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int rate;
    int win;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config passes samples through
    push_sample(24'h7FFFFF, 24'h800000, 24'h000000);
    push_sample(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    push_sample(24'h555555, 24'hAAAAAA, 24'h000001);
    drain();
    write_regs(1, 20);
    push_sample(24'h123456, 24'hFEDCBA, 24'h800000);
    drain();
    // zero max_window acts as a window of one
    write_regs(1023, 0);
    push_sample(24'h7FFFFF, 24'h800000, 24'hFFFFFE);
    push_sample(24'h800000, 24'h7FFFFF, 24'h000003);
    drain();
    // window of three: extreme sums, eviction, negative truncation
    write_regs(3, 20);
    push_sample(24'h7FFFFF, 24'h800000, 24'h000001);
    push_sample(24'h7FFFFF, 24'h800000, 24'hFFFFFE);
    push_sample(24'h7FFFFF, 24'h800000, 24'h000000);
    push_sample(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    push_sample(24'hFFFFFF, 24'h000000, 24'h000002);
    push_sample(24'hFFFFFE, 24'h000001, 24'hFFFFFD);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        src_idle_pct  = 73;
        sink_idle_pct = 17;
      end else if (p == 2 * PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      rate = (rate_set[p] < 0) ? int'($urandom_range(40)) : rate_set[p];
      win  = (win_set[p] < 0) ? int'($urandom_range(63)) : win_set[p];
      write_regs(rate, win);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_sample(rand_field(), rand_field(), rand_field());
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && mean_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
